// File: rtl/core/uf2v_pkg.sv
// shared types, register map and status codes for the uf2 image validator
package uf2v_pkg;

    // image and block geometry
    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned OFS_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned CNT_W       = 25;
    localparam int unsigned BLK_W       = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned STATUS_W    = 4;

    // stream widths
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 24;

    // configuration port
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_MAGIC   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_MAGIC  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRAILER_MAGIC = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FAMILY_ID     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_BYTES     = 3'd4;

    localparam logic [WORD_W-1:0] RST_FIRST_MAGIC   = 32'h0A32_4655;
    localparam logic [WORD_W-1:0] RST_SECOND_MAGIC  = 32'h9E5D_5157;
    localparam logic [WORD_W-1:0] RST_TRAILER_MAGIC = 32'h0AB1_6F30;
    localparam logic [WORD_W-1:0] RST_FAMILY_ID     = 32'hE48B_FF56;
    localparam logic [CNT_W-1:0]  RST_MAX_BYTES     = 25'd2097152;

    // byte offsets (inside a block) at which a little-endian word completes
    localparam logic [OFS_W-1:0] OFS_FIRST_MAGIC   = 9'd3;
    localparam logic [OFS_W-1:0] OFS_SECOND_MAGIC  = 9'd7;
    localparam logic [OFS_W-1:0] OFS_BLOCK_INDEX   = 9'd23;
    localparam logic [OFS_W-1:0] OFS_BLOCK_TOTAL   = 9'd27;
    localparam logic [OFS_W-1:0] OFS_FAMILY_ID     = 9'd31;
    localparam logic [OFS_W-1:0] OFS_TRAILER_MAGIC = 9'd511;

    // result status codes, lower nonzero code wins inside a block
    localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY         = 4'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_UNALIGNED     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_FIRST_MAGIC   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SECOND_MAGIC  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_TRAILER_MAGIC = 4'd6;
    localparam logic [STATUS_W-1:0] ST_FAMILY        = 4'd7;
    localparam logic [STATUS_W-1:0] ST_INDEX         = 4'd8;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [WORD_W-1:0] first_magic;
        logic [WORD_W-1:0] second_magic;
        logic [WORD_W-1:0] trailer_magic;
        logic [WORD_W-1:0] family_id;
        logic [CNT_W-1:0]  max_bytes;
    } cfg_t;

endpackage

// File: rtl/core/uf2v_cfg.sv
// apb configuration registers for the uf2 image validator
module uf2v_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [uf2v_pkg::ADDR_W-1:0]    paddr,
    input  logic [uf2v_pkg::PDATA_W-1:0]   pwdata,
    output logic [uf2v_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output uf2v_pkg::cfg_t                 cfg
);
    import uf2v_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // register write decode, unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_FIRST_MAGIC:   cfg_next.first_magic   = pwdata;
                REG_SECOND_MAGIC:  cfg_next.second_magic  = pwdata;
                REG_TRAILER_MAGIC: cfg_next.trailer_magic = pwdata;
                REG_FAMILY_ID:     cfg_next.family_id     = pwdata;
                REG_MAX_BYTES:     cfg_next.max_bytes     = pwdata[CNT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_magic   <= RST_FIRST_MAGIC;
            cfg_reg.second_magic  <= RST_SECOND_MAGIC;
            cfg_reg.trailer_magic <= RST_TRAILER_MAGIC;
            cfg_reg.family_id     <= RST_FAMILY_ID;
            cfg_reg.max_bytes     <= RST_MAX_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back mux
    always_comb
    begin
        unique case (reg_idx)
            REG_FIRST_MAGIC:   prdata = cfg_reg.first_magic;
            REG_SECOND_MAGIC:  prdata = cfg_reg.second_magic;
            REG_TRAILER_MAGIC: prdata = cfg_reg.trailer_magic;
            REG_FAMILY_ID:     prdata = cfg_reg.family_id;
            REG_MAX_BYTES:     prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.max_bytes};
            default:           prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/uf2_image_validator.sv
// uf2 image validator top level: byte stream in, one status beat per image out
// result path: a last beat is held in the input register, then its status in the result register
// throughput: one byte beat per cycle; a waiting result holds off the input
//   only while the input register carries the next last beat
// reset: rst_n clears the stream state and both valid flags at once and loads
//   the configuration registers with their defaults; no clearing pass
module uf2_image_validator
(
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uf2v_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] data_byte
    input  logic                           s_tuser,  // [0] byte_present
    input  logic                           s_tlast,  // is_last
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [uf2v_pkg::M_DATA_W-1:0]  m_tdata,  // [3:0] status, [19:4] blocks_seen
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [uf2v_pkg::ADDR_W-1:0]    paddr,
    input  logic [uf2v_pkg::PDATA_W-1:0]   pwdata,
    output logic [uf2v_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import uf2v_pkg::*;

    cfg_t cfg;

    // input stage
    logic                in_valid_reg;
    logic [S_DATA_W-1:0] in_byte_reg;
    logic                in_present_reg;
    logic                in_last_reg;

    // stream state
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [WORD_W-1:0]   word_reg,  word_next;
    logic [WORD_W-1:0]   first_total_reg, first_total_next;
    logic [WORD_W-1:0]   index_reg, index_next;
    logic [STATUS_W-1:0] blk_err_reg, blk_err_next;
    logic [STATUS_W-1:0] img_err_reg, img_err_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BLK_W-1:0]    out_blocks_reg, out_blocks_next;

    logic                out_free;
    logic                advance;
    logic [OFS_W-1:0]    offset;
    logic                first_block;
    logic                take;
    logic [WORD_W-1:0]   word_cur;
    logic [STATUS_W-1:0] be;
    logic [STATUS_W-1:0] ie;

    // keep the lower nonzero error code
    function automatic logic [STATUS_W-1:0] note_err(input logic [STATUS_W-1:0] cur,
                                                      input logic [STATUS_W-1:0] code);
        if (cur == ST_OK || code < cur)
            return code;
        return cur;
    endfunction

    uf2v_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipe moves unless a last beat waits for a result register that is full and not being taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = out_free || !(in_valid_reg && in_last_reg);
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-BLK_W-STATUS_W){1'b0}}, out_blocks_reg, out_status_reg};

    assign offset      = cnt_reg[OFS_W-1:0];
    assign first_block = (cnt_reg[CNT_W-1:OFS_W] == '0);
    assign take        = in_valid_reg && in_present_reg && !(&cnt_reg);
    assign word_cur    = {in_byte_reg, word_reg[WORD_W-1:S_DATA_W]};

    // per-byte block checks and end-of-image status
    always_comb
    begin
        cnt_next         = cnt_reg;
        word_next        = word_reg;
        first_total_next = first_total_reg;
        index_next       = index_reg;
        be               = blk_err_reg;
        ie               = img_err_reg;
        out_status_next  = out_status_reg;
        out_blocks_next  = out_blocks_reg;
        out_valid_next   = out_valid_reg;

        if (take)
        begin
            cnt_next  = cnt_reg + 1'b1;
            word_next = word_cur;
            if (offset == '0)
                be = ST_OK;
            unique case (offset)
                OFS_FIRST_MAGIC:
                begin
                    if (word_cur != cfg.first_magic)
                        be = note_err(be, ST_FIRST_MAGIC);
                end
                OFS_SECOND_MAGIC:
                begin
                    if (word_cur != cfg.second_magic)
                        be = note_err(be, ST_SECOND_MAGIC);
                end
                OFS_BLOCK_INDEX:
                begin
                    index_next = word_cur;
                end
                OFS_BLOCK_TOTAL:
                begin
                    if (first_block)
                        first_total_next = word_cur;
                    else if (word_cur != first_total_reg)
                        be = note_err(be, ST_INDEX);
                    if (index_reg >= word_cur)
                        be = note_err(be, ST_INDEX);
                end
                OFS_FAMILY_ID:
                begin
                    if (word_cur != cfg.family_id)
                        be = note_err(be, ST_FAMILY);
                end
                OFS_TRAILER_MAGIC:
                begin
                    if (word_cur != cfg.trailer_magic)
                        be = note_err(be, ST_TRAILER_MAGIC);
                    if (img_err_reg == ST_OK)
                        ie = be;
                end
                default:
                begin
                    be = be;
                end
            endcase
        end

        blk_err_next = be;
        img_err_next = ie;

        if (advance)
        begin
            // a held result stays until taken
            out_valid_next = out_valid_reg && !m_tready;
            if (in_valid_reg && in_last_reg)
            begin
                out_valid_next = 1'b1;
                // size errors first, then the first failing block
                priority if (cnt_next == '0)
                    out_status_next = ST_EMPTY;
                else if (cnt_next > cfg.max_bytes)
                    out_status_next = ST_TOO_LARGE;
                else if (cnt_next[OFS_W-1:0] != '0)
                    out_status_next = ST_UNALIGNED;
                else
                    out_status_next = ie;
                out_blocks_next = cnt_next[OFS_W +: BLK_W];

                // start the next image from scratch
                cnt_next         = '0;
                word_next        = '0;
                first_total_next = '0;
                index_next       = '0;
                blk_err_next     = ST_OK;
                img_err_next     = ST_OK;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            word_reg        <= '0;
            first_total_reg <= '0;
            index_reg       <= '0;
            blk_err_reg     <= ST_OK;
            img_err_reg     <= ST_OK;
        end
        else if (advance)
        begin
            in_valid_reg    <= s_tvalid;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            word_reg        <= word_next;
            first_total_reg <= first_total_next;
            index_reg       <= index_next;
            blk_err_reg     <= blk_err_next;
            img_err_reg     <= img_err_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
            out_status_reg <= out_status_next;
            out_blocks_reg <= out_blocks_next;
        end
    end

endmodule

// File: rtl/core/uf2v_checker.sv
// port-level checks for the uf2 image validator and their bind
module uf2v_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [uf2v_pkg::M_DATA_W-1:0] m_tdata
);
    import uf2v_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input is never held off while no result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // a new result follows an earlier accepted last beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a last beat");

    // status in range and padding clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] <= ST_INDEX)
                     && (m_tdata[M_DATA_W-1:STATUS_W+BLK_W] == '0))
        else $error("bad result encoding");

    // an empty image reports no blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STATUS_W-1:0] == ST_EMPTY)
            |-> (m_tdata[STATUS_W +: BLK_W] == '0))
        else $error("empty image with nonzero block count");

endmodule

bind uf2_image_validator uf2v_checker u_uf2v_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_uf2_image_validator.sv
// testbench for the uf2 image validator: byte images in, predicted verdicts checked beat by beat
module tb_uf2_image_validator;
    timeunit 1ns;
    timeprecision 1ps;

    import uf2v_pkg::*;

    // one verdict per image, as carried on m_tdata
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    blocks;
    } image_verdict_t;

    localparam logic [CNT_W-1:0]     CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
    localparam int WATCH_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CNT_W-1:0] MAX_BYTES_TOP = 25'd16777216;

    // block faults injected by the image builder
    localparam logic [5:0] FAULT_FIRST_MAGIC   = 6'b000001;
    localparam logic [5:0] FAULT_SECOND_MAGIC  = 6'b000010;
    localparam logic [5:0] FAULT_TRAILER_MAGIC = 6'b000100;
    localparam logic [5:0] FAULT_FAMILY        = 6'b001000;
    localparam logic [5:0] FAULT_TOTAL         = 6'b010000;
    localparam logic [5:0] FAULT_INDEX         = 6'b100000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [7:0] data_byte
    logic                s_tuser;   // [0] byte_present
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [3:0] status, [19:4] blocks_seen
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // image checker state mirrored in the testbench
    cfg_t                cfg_model;
    logic [CNT_W-1:0]    img_len;
    logic [WORD_W-1:0]   word_window;
    logic [WORD_W-1:0]   first_total;
    logic [WORD_W-1:0]   blk_index;
    logic [WORD_W-1:0]   blk_total;
    logic [STATUS_W-1:0] blk_err;
    logic [STATUS_W-1:0] img_err;

    image_verdict_t pending_verdicts[$];
    logic [7:0]     image_bytes[$];

    int error_count     = 0;
    int image_items     = 0;
    int verdicts_seen   = 0;
    int quiet_cycles    = 0;
    int src_gap_max     = 0;
    int sink_gap_max    = 0;
    int hold_off_cycles = 0;

    uf2_image_validator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [STATUS_W-1:0] worse_of(input logic [STATUS_W-1:0] held,
                                                     input logic [STATUS_W-1:0] code);
        return (held == ST_OK || code < held) ? code : held;
    endfunction

    function automatic void clear_image();
        img_len     = '0;
        word_window = '0;
        first_total = '0;
        blk_index   = '0;
        blk_total   = '0;
        blk_err     = ST_OK;
        img_err     = ST_OK;
    endfunction

    // one image byte: shift in little-endian, check the word that completes here
    function automatic void track_byte(input logic [7:0] b);
        if (img_len != CNT_MAX)
        begin
            if (img_len[OFS_W-1:0] == '0)
                blk_err = ST_OK;
            word_window = {b, word_window[WORD_W-1:8]};
            case (img_len[OFS_W-1:0])
                OFS_FIRST_MAGIC:
                    if (word_window != cfg_model.first_magic)
                        blk_err = worse_of(blk_err, ST_FIRST_MAGIC);
                OFS_SECOND_MAGIC:
                    if (word_window != cfg_model.second_magic)
                        blk_err = worse_of(blk_err, ST_SECOND_MAGIC);
                OFS_BLOCK_INDEX:
                    blk_index = word_window;
                OFS_BLOCK_TOTAL:
                begin
                    blk_total = word_window;
                    if (img_len < BLOCK_BYTES)
                        first_total = blk_total;
                    else if (blk_total != first_total)
                        blk_err = worse_of(blk_err, ST_INDEX);
                    if (blk_index >= blk_total)
                        blk_err = worse_of(blk_err, ST_INDEX);
                end
                OFS_FAMILY_ID:
                    if (word_window != cfg_model.family_id)
                        blk_err = worse_of(blk_err, ST_FAMILY);
                OFS_TRAILER_MAGIC:
                begin
                    if (word_window != cfg_model.trailer_magic)
                        blk_err = worse_of(blk_err, ST_TRAILER_MAGIC);
                    if (img_err == ST_OK)
                        img_err = blk_err;
                end
                default: ;
            endcase
            img_len = img_len + 1'b1;
        end
    endfunction

    // end of image: size checks first, then the first failing block
    function automatic void close_image();
        image_verdict_t v;
        if (img_len == '0)
            v.status = ST_EMPTY;
        else if (img_len > cfg_model.max_bytes)
            v.status = ST_TOO_LARGE;
        else if (img_len[OFS_W-1:0] != '0)
            v.status = ST_UNALIGNED;
        else
            v.status = img_err;
        v.blocks = img_len[CNT_W-1:OFS_W];
        pending_verdicts.push_back(v);
        clear_image();
    endfunction

    function automatic void store_register(input logic [REG_IDX_W-1:0] idx,
                                           input logic [PDATA_W-1:0] value);
        case (idx)
            REG_FIRST_MAGIC:   cfg_model.first_magic   = value;
            REG_SECOND_MAGIC:  cfg_model.second_magic  = value;
            REG_TRAILER_MAGIC: cfg_model.trailer_magic = value;
            REG_FAMILY_ID:     cfg_model.family_id     = value;
            REG_MAX_BYTES:     cfg_model.max_bytes     = value[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] register_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_FIRST_MAGIC:   return cfg_model.first_magic;
            REG_SECOND_MAGIC:  return cfg_model.second_magic;
            REG_TRAILER_MAGIC: return cfg_model.trailer_magic;
            REG_FAMILY_ID:     return cfg_model.family_id;
            REG_MAX_BYTES:     return PDATA_W'(cfg_model.max_bytes);
            default:           return '0;
        endcase
    endfunction

    // ---------------------------------------------------------------- monitors

    // accepted input beats feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            if (s_tuser || s_tlast)
                image_items++;
            if (s_tuser)
                track_byte(s_tdata);
            if (s_tlast)
                close_image();
        end
    end

    // accepted result beats against the oldest predicted verdict
    always @(posedge clk)
    begin : verdict_check
        image_verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with no image pending: m_tdata=%h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_tdata[STATUS_W-1:0] != want.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           want.status, m_tdata[STATUS_W-1:0]);
                    error_count++;
                end
                if (m_tdata[STATUS_W +: BLK_W] != want.blocks)
                begin
                    $error("blocks_seen: expected %0d, actual %0d",
                           want.blocks, m_tdata[STATUS_W +: BLK_W]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat or register access
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("uf2_image_validator verification failed");
            $finish;
        end
    end

    // result receiver: random stalls, long hold-off on request
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = (hold_off_cycles > 0) ? hold_off_cycles : $urandom_range(0, sink_gap_max);
            hold_off_cycles = 0;
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_beat(input logic [7:0] data, input logic present, input logic last);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop offering and wait until every verdict is back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        if (write)
            store_register(idx, wdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
    endtask

    task automatic check_registers();
        logic [PDATA_W-1:0] got;
        for (int r = REG_FIRST_MAGIC; r <= REG_MAX_BYTES; r++)
        begin
            apb_access(1'b0, REG_IDX_W'(r), '0, got);
            if (got != register_value(REG_IDX_W'(r)))
            begin
                $error("register %0d: expected %h, actual %h",
                       r, register_value(REG_IDX_W'(r)), got);
                error_count++;
            end
        end
    endtask

    task automatic load_config(input logic [WORD_W-1:0] fm, input logic [WORD_W-1:0] sm,
                               input logic [WORD_W-1:0] tm, input logic [WORD_W-1:0] fam,
                               input logic [CNT_W-1:0] max_len);
        write_register(REG_FIRST_MAGIC, fm);
        write_register(REG_SECOND_MAGIC, sm);
        write_register(REG_TRAILER_MAGIC, tm);
        write_register(REG_FAMILY_ID, fam);
        write_register(REG_MAX_BYTES, PDATA_W'(max_len));
    endtask

    // ---------------------------------------------------------------- image builder

    function automatic logic [WORD_W-1:0] corrupt_word(input logic [WORD_W-1:0] w);
        if ($urandom_range(0, 1) != 0)
            return w ^ (32'h1 << $urandom_range(0, 31));
        return w ^ ($urandom | 32'h1);
    endfunction

    // one 512-byte block with random payload and optional header or trailer faults
    task automatic append_block(input logic [WORD_W-1:0] index, input logic [WORD_W-1:0] total,
                                input logic [5:0] faults);
        logic [WORD_W-1:0] w [128];
        for (int i = 0; i < 128; i++)
            w[i] = $urandom;
        w[0]   = cfg_model.first_magic;
        w[1]   = cfg_model.second_magic;
        w[5]   = index;
        w[6]   = total;
        w[7]   = cfg_model.family_id;
        w[127] = cfg_model.trailer_magic;
        if ((faults & FAULT_FIRST_MAGIC) != 0)   w[0]   = corrupt_word(w[0]);
        if ((faults & FAULT_SECOND_MAGIC) != 0)  w[1]   = corrupt_word(w[1]);
        if ((faults & FAULT_TRAILER_MAGIC) != 0) w[127] = corrupt_word(w[127]);
        if ((faults & FAULT_FAMILY) != 0)        w[7]   = corrupt_word(w[7]);
        if ((faults & FAULT_TOTAL) != 0)         w[6]   = corrupt_word(w[6]);
        // index at or just past the total
        if ((faults & FAULT_INDEX) != 0)
            w[5] = (w[6] >= 32'hFFFF_FFFD) ? w[6] : w[6] + $urandom_range(0, 2);
        for (int i = 0; i < 128; i++)
            for (int k = 0; k < 4; k++)
                image_bytes.push_back(w[i][8*k +: 8]);
    endtask

    task automatic build_uf2_image(input int n_blocks, input int fault_pct);
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] index;
        logic [5:0]        faults;
        total = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                             : WORD_W'(n_blocks + $urandom_range(0, 3));
        for (int b = 0; b < n_blocks; b++)
        begin
            faults = '0;
            if ($urandom_range(0, 99) < fault_pct)
                faults = ($urandom_range(0, 1) != 0) ? 6'(1 << $urandom_range(0, 5))
                                                      : 6'($urandom_range(1, 63));
            index = ($urandom_range(0, 1) != 0) ? WORD_W'(b) : $urandom % total;
            append_block(index, total, faults);
        end
    endtask

    // send the built image, with stray byte-less beats; optionally end on a byte-less beat
    task automatic stream_image(input bit absent_end);
        int n;
        n = image_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(image_bytes[i], 1'b1, !absent_end && i == n - 1);
        end
        if (absent_end || n == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
        image_bytes.delete();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_register_map();
        check_registers();
        load_config(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, MAX_BYTES_TOP);
        check_registers();
        write_register(REG_UNMAPPED, $urandom);
        check_registers();
        write_register(REG_MAX_BYTES, '0);
        check_registers();
        load_config(RST_FIRST_MAGIC, RST_SECOND_MAGIC, RST_TRAILER_MAGIC, RST_FAMILY_ID,
                    RST_MAX_BYTES);
        check_registers();
    endtask

    task automatic test_short_images();
        src_gap_max  = 16;
        sink_gap_max = 16;
        // empty image, single bytes at both extremes
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        // stray byte-less beat inside, byte-less last beat at the end
        send_beat(8'hA5, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b0);
        send_beat(8'h3C, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_block_checks();
        logic [5:0] faults;
        src_gap_max  = 4;
        sink_gap_max = 4;
        // clean single-block image
        append_block(0, 1, '0);
        stream_image(1'b0);
        // one block with a random set of header or trailer faults
        faults = ($urandom_range(0, 1) != 0) ? 6'(1 << $urandom_range(0, 5))
                                              : 6'($urandom_range(1, 63));
        append_block(0, 1, faults);
        stream_image($urandom_range(0, 1) != 0);
        wait_drained();
    endtask

    task automatic test_size_limits();
        src_gap_max  = 2;
        sink_gap_max = 2;
        write_register(REG_MAX_BYTES, '0);
        send_beat(8'h81, 1'b1, 1'b1);
        send_beat(8'h18, 1'b0, 1'b1);
        wait_drained();
        // image length at the limit, then one byte over
        write_register(REG_MAX_BYTES, PDATA_W'(8));
        repeat (8) image_bytes.push_back(8'($urandom));
        stream_image(1'b0);
        repeat (9) image_bytes.push_back(8'($urandom));
        stream_image(1'b1);
        wait_drained();
        write_register(REG_MAX_BYTES, PDATA_W'(MAX_BYTES_TOP));
        repeat (20) image_bytes.push_back(8'($urandom));
        stream_image(1'b0);
        wait_drained();
        write_register(REG_MAX_BYTES, PDATA_W'(RST_MAX_BYTES));
    endtask

    // receiver holds off while short images keep coming
    task automatic test_back_pressure();
        src_gap_max     = 0;
        sink_gap_max    = 0;
        hold_off_cycles = 400;
        repeat (16)
        begin
            repeat ($urandom_range(1, 3)) image_bytes.push_back(8'($urandom));
            stream_image(1'b0);
        end
        wait_drained();
    endtask

    task automatic run_traffic_phase(input int min_items, input int min_verdicts);
        int items0;
        int verdicts0;
        int pick;
        int cut;
        items0    = image_items;
        verdicts0 = verdicts_seen;
        while (image_items - items0 < min_items || verdicts_seen - verdicts0 < min_verdicts)
        begin
            src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 16;
            sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // header of a block, possibly with faults, cut short
                build_uf2_image(1, 35);
                cut = $urandom_range(1, 48);
                while (image_bytes.size() > cut)
                    void'(image_bytes.pop_back());
            end
            else if (pick < 95)
                repeat ($urandom_range(1, 40)) image_bytes.push_back(8'($urandom));
            stream_image($urandom_range(0, 4) == 0);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(100, 4);
        load_config($urandom, $urandom, $urandom, $urandom, 25'd24);
        run_traffic_phase(100, 4);
        load_config(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, MAX_BYTES_TOP);
        run_traffic_phase(100, 4);
        load_config(RST_FIRST_MAGIC, RST_SECOND_MAGIC, RST_TRAILER_MAGIC, RST_FAMILY_ID,
                    25'd16);
        run_traffic_phase(100, 4);
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_model.first_magic   = RST_FIRST_MAGIC;
        cfg_model.second_magic  = RST_SECOND_MAGIC;
        cfg_model.trailer_magic = RST_TRAILER_MAGIC;
        cfg_model.family_id     = RST_FAMILY_ID;
        cfg_model.max_bytes     = RST_MAX_BYTES;
        clear_image();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_register_map();
        test_short_images();
        test_block_checks();
        test_size_limits();
        test_back_pressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("uf2_image_validator verification clean");
        else
            $display("uf2_image_validator verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/uf2v_pkg.sv
rtl/core/uf2v_cfg.sv
rtl/core/uf2_image_validator.sv
rtl/core/uf2v_checker.sv
tb/tb_uf2_image_validator.sv
